FILE: rtl/core/ulc_pkg.sv
// Shared types, widths and constants of the unit square line clipper.
package ulc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_WIDTH     = 24;
    localparam int PIXEL_BITS      = 13;

    // Quotient magnitude bits, divisor bits, product and numerator bits.
    localparam int QUO_W  = COORD_WIDTH;
    localparam int DEN_W  = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * COORD_WIDTH + 1;
    localparam int NUM_W  = PROD_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int IN_DATA_W  = 4 * COORD_WIDTH;
    localparam int OUT_DATA_W = ((4 * PIXEL_BITS + 7) / 8) * 8;
    localparam int SCALE_W    = PIXEL_BITS + COORD_FRAC_BITS + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COORD_WIDTH:0]   wcoord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [NUM_W-1:0]       num_t;
    typedef logic [DEN_W-1:0]              den_t;
    typedef logic [PIXEL_BITS-1:0]         pixel_t;

    localparam coord_t ONE_FX = coord_t'(1 << COORD_FRAC_BITS);

    // Configuration register indexes.
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd1;

    localparam pixel_t WIDTH_RESET  = pixel_t'(640);
    localparam pixel_t HEIGHT_RESET = pixel_t'(480);

    typedef enum logic [1:0] {
        STEP_X_LO,
        STEP_X_HI,
        STEP_Y_LO,
        STEP_Y_HI
    } step_mode_t;

    typedef struct packed {
        logic   live;
        logic   draw;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } seg_t;

    typedef struct packed {
        seg_t             seg;
        logic             need;
        logic             neg;
        logic [NUM_W-1:0] rem;
        den_t             den;
        logic [QUO_W-1:0] quo;
    } div_stage_t;

endpackage

FILE: rtl/core/unit_square_line_clipper_unit.sv
// Top level of the unit square line clipper.
//
// Segments arrive on the s_ stream: four Q7.16 coordinates in tdata and the
// draw/erase flag in tuser. A segment that survives clipping leaves on the
// m_ stream as four truncated pixel coordinates plus the flag; a dropped
// segment produces no result. Window width and height are written through
// the cfg channel (index 0 width, index 1 height) by the user only while the
// block is idle, which the block does not enforce. One segment is accepted
// per cycle, sustained, while results are taken. A segment passes the front
// end register, the queue, the x clip steps, the second y test, the y clip
// steps and the output register; each clip step is a multiply stage, a divider
// of one quotient bit per stage plus an input and an output stage, and an
// update stage. The front end feeds a four-entry queue; when the receiver
// stalls the clipping pipeline holds, the queue fills and then s_tready drops.
// Reset empties the pipeline and queue and loads width 640, height 480.
module unit_square_line_clipper_unit
    import ulc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                  s_tuser,   // draw_not_erase
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_x_a, pixel_y_a, pixel_x_b, pixel_y_b
    output logic                  m_tuser,   // draw_flag
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [PIXEL_BITS-1:0] cfg_data
);

    pixel_t win_w_reg, win_h_reg;
    logic   push_valid, push_ready;
    seg_t   push_seg;
    logic   pop_valid, pop_en;
    seg_t   pop_seg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= WIDTH_RESET;
            win_h_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_WIDTH:  win_w_reg <= cfg_data;
                REG_WINDOW_HEIGHT: win_h_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    ulc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_seg   (push_seg)
    );

    ulc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_seg   (push_seg),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_seg    (pop_seg)
    );

    ulc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_en    (pop_en),
        .pop_seg   (pop_seg),
        .win_w     (win_w_reg),
        .win_h     (win_h_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/core/ulc_front.sv
// Front end: accepts segments, drops trivially outside ones, orders ends by x.
module ulc_front
    import ulc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                 s_tuser,   // draw_not_erase
    output logic                 push_valid,
    input  logic                 push_ready,
    output seg_t                 push_seg
);

    logic   valid_reg, valid_next;
    seg_t   seg_reg, seg_next;
    coord_t sx, sy, ex, ey;
    logic   drop;

    assign sx = coord_t'(s_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
    assign sy = coord_t'(s_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
    assign ex = coord_t'(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
    assign ey = coord_t'(s_tdata[3*COORD_WIDTH +: COORD_WIDTH]);

    assign drop = (sx <= 0 && ex <= 0) || (sx >= ONE_FX && ex >= ONE_FX) ||
                  (sy <= 0 && ey <= 0) || (sy >= ONE_FX && ey >= ONE_FX);

    assign s_tready = !valid_reg || push_ready;

    always_comb
    begin
        valid_next = valid_reg;
        seg_next   = seg_reg;
        if (s_tready)
        begin
            valid_next    = s_tvalid && !drop;
            seg_next.live = 1'b1;
            seg_next.draw = s_tuser;
            if (ex < sx)
            begin
                seg_next.x0 = ex;
                seg_next.y0 = ey;
                seg_next.x1 = sx;
                seg_next.y1 = sy;
            end
            else
            begin
                seg_next.x0 = sx;
                seg_next.y0 = sy;
                seg_next.x1 = ex;
                seg_next.y1 = ey;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    assign push_valid = valid_reg;
    assign push_seg   = seg_reg;

endmodule

FILE: rtl/core/ulc_queue.sv
// Short queue between the front end and the clipping pipeline.
module ulc_queue
    import ulc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  seg_t push_seg,
    output logic pop_valid,
    input  logic pop_en,
    output seg_t pop_seg
);

    seg_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;
    assign pop_seg    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_seg;
        end
    end

endmodule

FILE: rtl/core/ulc_div.sv
// Pipelined restoring divider, one quotient bit per stage, segment rides along.
module ulc_div
    import ulc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  seg_t   in_seg,
    input  logic   in_need,
    input  num_t   in_num,
    input  den_t   in_den,
    output seg_t   out_seg,
    output logic   out_need,
    output coord_t out_quo
);

    div_stage_t st_reg  [QUO_W+1];
    div_stage_t st_next [QUO_W+1];
    seg_t       fin_seg_reg, fin_seg_next;
    logic       fin_need_reg, fin_need_next;
    coord_t     fin_quo_reg, fin_quo_next;

    always_comb
    begin
        logic [NUM_W-1:0] sh;
        logic [QUO_W:0]   mag;
        logic [QUO_W:0]   sval;

        st_next[0].seg  = in_seg;
        st_next[0].need = in_need;
        st_next[0].neg  = in_num[NUM_W-1];
        st_next[0].rem  = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
        st_next[0].den  = in_den;
        st_next[0].quo  = '0;

        // Each stage settles one quotient bit, most significant first.
        for (int i = 1; i <= QUO_W; i++)
        begin
            st_next[i] = st_reg[i-1];
            sh = NUM_W'(st_reg[i-1].den) << (QUO_W - i);
            if (st_reg[i-1].rem >= sh)
            begin
                st_next[i].rem          = st_reg[i-1].rem - sh;
                st_next[i].quo[QUO_W-i] = 1'b1;
            end
        end

        mag  = {1'b0, st_reg[QUO_W].quo};
        sval = st_reg[QUO_W].neg ? -mag : mag;
        fin_seg_next  = st_reg[QUO_W].seg;
        fin_need_next = st_reg[QUO_W].need;
        fin_quo_next  = coord_t'(sval[COORD_WIDTH-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUO_W; i++)
            begin
                st_reg[i] <= '0;
            end
            fin_seg_reg  <= '0;
            fin_need_reg <= 1'b0;
            fin_quo_reg  <= '0;
        end
        else if (en)
        begin
            st_reg       <= st_next;
            fin_seg_reg  <= fin_seg_next;
            fin_need_reg <= fin_need_next;
            fin_quo_reg  <= fin_quo_next;
        end
    end

    assign out_seg  = fin_seg_reg;
    assign out_need = fin_need_reg;
    assign out_quo  = fin_quo_reg;

endmodule

FILE: rtl/core/ulc_step.sv
// One clipping step: interpolate an end onto a square edge through the divider.
module ulc_step
    import ulc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  step_mode_t mode,
    input  seg_t       in_seg,
    output seg_t       out_seg
);

    coord_t  u0, v0, u1, v1;
    logic    hi, need;
    wcoord_t a, c, d;
    seg_t    prep_seg_reg;
    logic    prep_need_reg;
    prod_t   p1_reg, p2_reg;
    den_t    den_reg;
    seg_t    div_seg;
    logic    div_need;
    coord_t  div_quo;
    seg_t    app_seg_reg, app_seg_next;

    always_comb
    begin
        case (mode)
            STEP_Y_LO, STEP_Y_HI:
            begin
                u0 = in_seg.y0;
                v0 = in_seg.x0;
                u1 = in_seg.y1;
                v1 = in_seg.x1;
            end
            default:
            begin
                u0 = in_seg.x0;
                v0 = in_seg.y0;
                u1 = in_seg.x1;
                v1 = in_seg.y1;
            end
        endcase
        hi   = (mode == STEP_X_HI) || (mode == STEP_Y_HI);
        need = in_seg.live && (u0 < u1) && (hi ? (u1 > ONE_FX) : (u0 < 0));
        a    = hi ? wcoord_t'(u1) - wcoord_t'(ONE_FX) : wcoord_t'(u1);
        c    = hi ? wcoord_t'(u0) - wcoord_t'(ONE_FX) : wcoord_t'(u0);
        d    = wcoord_t'(u1) - wcoord_t'(u0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_seg_reg  <= '0;
            prep_need_reg <= 1'b0;
            app_seg_reg   <= '0;
        end
        else if (en)
        begin
            prep_seg_reg  <= in_seg;
            prep_need_reg <= need;
            app_seg_reg   <= app_seg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= prod_t'(a) * prod_t'(v0);
            p2_reg  <= prod_t'(c) * prod_t'(v1);
            den_reg <= den_t'(d);
        end
    end

    ulc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_seg   (prep_seg_reg),
        .in_need  (prep_need_reg),
        .in_num   (num_t'(p1_reg) - num_t'(p2_reg)),
        .in_den   (den_reg),
        .out_seg  (div_seg),
        .out_need (div_need),
        .out_quo  (div_quo)
    );

    // Replace the clipped end with the edge point.
    always_comb
    begin
        app_seg_next = div_seg;
        if (div_need)
        begin
            case (mode)
                STEP_X_LO:
                begin
                    app_seg_next.x0 = '0;
                    app_seg_next.y0 = div_quo;
                end
                STEP_X_HI:
                begin
                    app_seg_next.x1 = ONE_FX;
                    app_seg_next.y1 = div_quo;
                end
                STEP_Y_LO:
                begin
                    app_seg_next.y0 = '0;
                    app_seg_next.x0 = div_quo;
                end
                default:
                begin
                    app_seg_next.y1 = ONE_FX;
                    app_seg_next.x1 = div_quo;
                end
            endcase
        end
    end

    assign out_seg = app_seg_reg;

endmodule

FILE: rtl/core/ulc_back.sv
// Back end: x clipping, second y test and y ordering, y clipping, pixel scaling.
module ulc_back
    import ulc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_en,
    input  seg_t                  pop_seg,
    input  pixel_t                win_w,
    input  pixel_t                win_h,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    logic   adv;
    seg_t   head;
    seg_t   xlo_seg, xhi_seg, ylo_seg, yhi_seg;
    seg_t   mid_reg, mid_next;
    logic   out_valid_reg;
    logic   out_draw_reg;
    pixel_t pxa_reg, pya_reg, pxb_reg, pyb_reg;

    // Whole pipeline advances while the output slot is free or being taken.
    assign adv    = !out_valid_reg || m_tready;
    assign pop_en = adv;

    always_comb
    begin
        head      = pop_seg;
        head.live = pop_valid;
    end

    ulc_step u_xlo (
        .clk (clk), .rst_n (rst_n), .en (adv), .mode (STEP_X_LO),
        .in_seg (head), .out_seg (xlo_seg)
    );

    ulc_step u_xhi (
        .clk (clk), .rst_n (rst_n), .en (adv), .mode (STEP_X_HI),
        .in_seg (xlo_seg), .out_seg (xhi_seg)
    );

    always_comb
    begin
        mid_next = xhi_seg;
        if ((xhi_seg.y0 <= 0 && xhi_seg.y1 <= 0) ||
            (xhi_seg.y0 >= ONE_FX && xhi_seg.y1 >= ONE_FX))
        begin
            mid_next.live = 1'b0;
        end
        if (xhi_seg.y1 < xhi_seg.y0)
        begin
            mid_next.x0 = xhi_seg.x1;
            mid_next.y0 = xhi_seg.y1;
            mid_next.x1 = xhi_seg.x0;
            mid_next.y1 = xhi_seg.y0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
        end
        else if (adv)
        begin
            mid_reg <= mid_next;
        end
    end

    ulc_step u_ylo (
        .clk (clk), .rst_n (rst_n), .en (adv), .mode (STEP_Y_LO),
        .in_seg (mid_reg), .out_seg (ylo_seg)
    );

    ulc_step u_yhi (
        .clk (clk), .rst_n (rst_n), .en (adv), .mode (STEP_Y_HI),
        .in_seg (ylo_seg), .out_seg (yhi_seg)
    );

    function automatic pixel_t to_pixel(input pixel_t size, input coord_t c);
        logic [COORD_FRAC_BITS:0] cu;
        logic [SCALE_W-1:0]       prod;
        if (c < 0)
        begin
            cu = '0;
        end
        else if (c > ONE_FX)
        begin
            cu = (COORD_FRAC_BITS+1)'(ONE_FX);
        end
        else
        begin
            cu = c[COORD_FRAC_BITS:0];
        end
        prod = SCALE_W'(size) * SCALE_W'(cu);
        return prod[COORD_FRAC_BITS +: PIXEL_BITS];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= yhi_seg.live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_draw_reg <= yhi_seg.draw;
            pxa_reg      <= to_pixel(win_w, yhi_seg.x0);
            pya_reg      <= to_pixel(win_h, yhi_seg.y0);
            pxb_reg      <= to_pixel(win_w, yhi_seg.x1);
            pyb_reg      <= to_pixel(win_h, yhi_seg.y1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_draw_reg;
    assign m_tdata  = OUT_DATA_W'({pyb_reg, pxb_reg, pya_reg, pxa_reg});

endmodule
